FILE: rtl/rbsi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ray/box slab intersect package
// Shared types and constants for the slab intersect pipeline.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   localparam int unsigned NUM_AXES = 3;
   localparam int unsigned COORD_W  = 32;
   localparam int unsigned CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_MIN_X = 3'd0,
      CSR_BOX_MIN_Y = 3'd1,
      CSR_BOX_MIN_Z = 3'd2,
      CSR_BOX_MAX_X = 3'd3,
      CSR_BOX_MAX_Y = 3'd4,
      CSR_BOX_MAX_Z = 3'd5
   } csr_idx_type;

   localparam logic signed [COORD_W-1:0] BOX_MIN_RESET = -32'sd65536;
   localparam logic signed [COORD_W-1:0] BOX_MAX_RESET = 32'sd65536;

   // Per-axis status that travels with a plane distance pair.
   typedef struct packed {
      logic zero_dir;
      logic contained;
   } slab_flags_type;

endpackage : rbsi_pkg
`default_nettype wire

FILE: rtl/rbsi_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Restoring division, BITS_PER_STAGE quotient bits per register stage,
// truncating toward zero. Stalls with the shared enable.
// ----------------------------------------------------------------------------
module rbsi_divider #(
   parameter int unsigned NUM_W = 57,
   parameter int unsigned DEN_W = 32,
   parameter int unsigned BITS_PER_STAGE = 8,
   parameter int unsigned TAG_W = 1
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     enable,
   input  wire                     in_valid,
   input  wire signed [NUM_W-1:0]  in_num,
   input  wire signed [DEN_W-1:0]  in_den,
   input  wire        [TAG_W-1:0]  in_tag,
   output logic                    out_valid,
   output logic signed [NUM_W-1:0] out_quot,
   output logic       [TAG_W-1:0]  out_tag
);

   localparam int unsigned STAGES = (NUM_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
   localparam int unsigned PAD_W  = STAGES * BITS_PER_STAGE;

   // Stage registers; index 0 is the input capture.
   logic [STAGES:0]             valid_ff;
   logic [PAD_W-1:0]            rem_num_ff [STAGES+1];
   logic [DEN_W:0]              part_ff    [STAGES+1];
   logic [DEN_W-1:0]            den_ff     [STAGES+1];
   logic                        neg_ff     [STAGES+1];
   logic [TAG_W-1:0]            tag_ff     [STAGES+1];

   logic [NUM_W-1:0] abs_num;
   logic [DEN_W-1:0] abs_den;

   assign abs_num = in_num[NUM_W-1] ? NUM_W'(-in_num) : in_num;
   assign abs_den = in_den[DEN_W-1] ? DEN_W'(-in_den) : in_den;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
      if (enable) begin
         rem_num_ff[0] <= PAD_W'(abs_num);
         part_ff[0]    <= '0;
         den_ff[0]     <= abs_den;
         neg_ff[0]     <= in_num[NUM_W-1] ^ in_den[DEN_W-1];
         tag_ff[0]     <= in_tag;
      end
   end

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [PAD_W-1:0] num_in;
      logic [DEN_W:0]   part_in;

      // The numerator register shifts out dividend bits at the top and
      // collects quotient bits at the bottom.
      always_comb begin
         logic [DEN_W+1:0] trial;
         logic             q;
         num_in  = rem_num_ff[s];
         part_in = part_ff[s];
         for (int b = 0; b < BITS_PER_STAGE; b++) begin
            trial   = {part_in, num_in[PAD_W-1]} - {2'b00, den_ff[s]};
            q       = ~trial[DEN_W+1];
            part_in = q ? trial[DEN_W:0] : {part_in[DEN_W-1:0], num_in[PAD_W-1]};
            num_in  = {num_in[PAD_W-2:0], q};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[s+1] <= valid_ff[s];
         end
         if (enable) begin
            rem_num_ff[s+1] <= num_in;
            part_ff[s+1]    <= part_in;
            den_ff[s+1]     <= den_ff[s];
            neg_ff[s+1]     <= neg_ff[s];
            tag_ff[s+1]     <= tag_ff[s];
         end
      end
   end

   logic [NUM_W-1:0] mag;
   assign mag       = rem_num_ff[STAGES][NUM_W-1:0];
   assign out_valid = valid_ff[STAGES];
   assign out_quot  = neg_ff[STAGES] ? NUM_W'(-mag) : mag;
   assign out_tag   = tag_ff[STAGES];

endmodule : rbsi_divider
`default_nettype wire

FILE: rtl/rbsi_axis_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slab axis front end
// Forms the two scaled plane numerators of one axis and the zero-direction
// containment flags, registered.
// ----------------------------------------------------------------------------
module rbsi_axis_front #(
   parameter int unsigned FRAC_BITS = 16,
   parameter int unsigned NUM_W = 57
) (
   input  wire                            clock,
   input  wire                            enable,
   input  wire signed [31:0]              box_lo,
   input  wire signed [31:0]              box_hi,
   input  wire signed [31:0]              origin,
   input  wire signed [31:0]              dir,
   output logic signed [NUM_W-1:0]        num_lo_ff,
   output logic signed [NUM_W-1:0]        num_hi_ff,
   output logic signed [31:0]             dir_ff,
   output rbsi_pkg::slab_flags_type       flags_ff
);
   import rbsi_pkg::*;

   logic signed [32:0] diff_lo, diff_hi;
   slab_flags_type     flags_in;

   assign diff_lo = 33'(box_lo) - 33'(origin);
   assign diff_hi = 33'(box_hi) - 33'(origin);

   always_comb begin
      flags_in.zero_dir  = (dir == '0);
      flags_in.contained = (box_lo <= origin) && (origin <= box_hi);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         num_lo_ff <= NUM_W'(diff_lo) <<< FRAC_BITS;
         num_hi_ff <= NUM_W'(diff_hi) <<< FRAC_BITS;
         dir_ff    <= dir;
         flags_ff  <= flags_in;
      end
   end

endmodule : rbsi_axis_front
`default_nettype wire

FILE: rtl/ray_box_slab_intersect_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ray/box slab intersect unit
// Tests a stream of rays against one axis-aligned box by the slab method.
// ----------------------------------------------------------------------------
// The unit accepts one ray per clock cycle, unless stalled, and returns one
// result per ray in order. Most of its pipeline lies in the six pipelined
// dividers that produce the plane distances, eight quotient bits per stage.
// The whole pipeline stalls while a result waits at the output; the box
// registers should be written only when the unit is empty.
module ray_box_slab_intersect_unit #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire signed [31:0] req_origin_x,
   input  wire signed [31:0] req_origin_y,
   input  wire signed [31:0] req_origin_z,
   input  wire signed [31:0] req_dir_x,
   input  wire signed [31:0] req_dir_y,
   input  wire signed [31:0] req_dir_z,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic              rsp_hit,
   output logic signed [31:0] rsp_entry_distance,
   input  wire               csr_write,
   input  wire [rbsi_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [31:0]        csr_data
);
   import rbsi_pkg::*;

   localparam int unsigned NUM_W  = 34 + FRAC_BITS;
   localparam int unsigned DIST_W = NUM_W + 1;
   localparam int unsigned TAG_W  = 2;

   logic enable;
   logic signed [31:0] box_min_ff [NUM_AXES];
   logic signed [31:0] box_max_ff [NUM_AXES];
   logic signed [31:0] origin [NUM_AXES];
   logic signed [31:0] dir    [NUM_AXES];

   assign origin[0] = req_origin_x;
   assign origin[1] = req_origin_y;
   assign origin[2] = req_origin_z;
   assign dir[0] = req_dir_x;
   assign dir[1] = req_dir_y;
   assign dir[2] = req_dir_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            box_min_ff[a] <= BOX_MIN_RESET;
            box_max_ff[a] <= BOX_MAX_RESET;
         end
      end else if (csr_write) begin
         case (csr_index)
            CSR_BOX_MIN_X: box_min_ff[0] <= csr_data;
            CSR_BOX_MIN_Y: box_min_ff[1] <= csr_data;
            CSR_BOX_MIN_Z: box_min_ff[2] <= csr_data;
            CSR_BOX_MAX_X: box_max_ff[0] <= csr_data;
            CSR_BOX_MAX_Y: box_max_ff[1] <= csr_data;
            CSR_BOX_MAX_Z: box_max_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // Output register: the pipeline advances whenever it is empty or taken.
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   logic                    front_valid_ff;
   logic [NUM_AXES-1:0]     div_valid;
   logic signed [DIST_W-1:0] dist_lo [NUM_AXES];
   logic signed [DIST_W-1:0] dist_hi [NUM_AXES];
   slab_flags_type          flags_out [NUM_AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (enable) begin
         front_valid_ff <= req_valid;
      end
   end

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      logic signed [NUM_W-1:0] num_lo, num_hi, q_lo, q_hi;
      logic signed [31:0]      dir_r;
      slab_flags_type          flags_r;
      logic [TAG_W-1:0]        tag_lo, tag_hi;
      logic                    v_lo, v_hi;

      rbsi_axis_front #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_front (
         .clock(clock), .enable(enable),
         .box_lo(box_min_ff[a]), .box_hi(box_max_ff[a]),
         .origin(origin[a]), .dir(dir[a]),
         .num_lo_ff(num_lo), .num_hi_ff(num_hi),
         .dir_ff(dir_r), .flags_ff(flags_r)
      );

      // A zero divisor yields junk that is masked by the zero_dir flag.
      rbsi_divider #(.NUM_W(NUM_W), .DEN_W(32), .TAG_W(TAG_W)) u_div_lo (
         .clock(clock), .reset(reset), .enable(enable),
         .in_valid(front_valid_ff), .in_num(num_lo), .in_den(dir_r),
         .in_tag(flags_r), .out_valid(v_lo), .out_quot(q_lo),
         .out_tag(tag_lo)
      );
      rbsi_divider #(.NUM_W(NUM_W), .DEN_W(32), .TAG_W(TAG_W)) u_div_hi (
         .clock(clock), .reset(reset), .enable(enable),
         .in_valid(front_valid_ff), .in_num(num_hi), .in_den(dir_r),
         .in_tag(flags_r), .out_valid(v_hi), .out_quot(q_hi),
         .out_tag(tag_hi)
      );

      assign div_valid[a] = v_lo && v_hi;
      assign dist_lo[a]   = DIST_W'(q_lo);
      assign dist_hi[a]   = DIST_W'(q_hi);
      assign flags_out[a] = slab_flags_type'(tag_lo);
   end

   // Stage A: order each pair.
   logic                     a_valid_ff;
   logic signed [DIST_W-1:0] a_near_ff [NUM_AXES];
   logic signed [DIST_W-1:0] a_far_ff  [NUM_AXES];
   slab_flags_type           a_flags_ff [NUM_AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= &div_valid;
      end
      if (enable) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            a_near_ff[a]  <= (dist_lo[a] < dist_hi[a]) ? dist_lo[a] : dist_hi[a];
            a_far_ff[a]   <= (dist_lo[a] < dist_hi[a]) ? dist_hi[a] : dist_lo[a];
            a_flags_ff[a] <= flags_out[a];
         end
      end
   end

   // Stage B: narrow the interval across axes and flag zero-direction misses.
   logic                     b_valid_ff, b_miss_ff, b_bounded_ff;
   logic signed [DIST_W-1:0] b_near_ff, b_far_ff;

   always_ff @(posedge clock) begin
      logic signed [DIST_W-1:0] near_v, far_v;
      logic                     miss_v, bounded_v;
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         b_valid_ff <= a_valid_ff;
      end
      near_v    = '0;
      far_v     = '0;
      miss_v    = 1'b0;
      bounded_v = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         if (a_flags_ff[a].zero_dir) begin
            miss_v = miss_v | !a_flags_ff[a].contained;
         end else begin
            if (!bounded_v || a_near_ff[a] > near_v) near_v = a_near_ff[a];
            if (!bounded_v || a_far_ff[a] < far_v) far_v = a_far_ff[a];
            bounded_v = 1'b1;
         end
      end
      if (enable) begin
         b_near_ff    <= near_v;
         b_far_ff     <= far_v;
         b_miss_ff    <= miss_v;
         b_bounded_ff <= bounded_v;
      end
   end

   // Output stage: hit decision and saturation.
   localparam logic signed [DIST_W-1:0] SAT_MAX = DIST_W'(32'sh7fffffff);
   localparam logic signed [DIST_W-1:0] SAT_MIN = -(DIST_W'(64'sh80000000));

   logic        hit_in;
   logic [31:0] entry_in;

   always_comb begin
      if (b_miss_ff) begin
         hit_in   = 1'b0;
         entry_in = '0;
      end else if (!b_bounded_ff) begin
         hit_in   = 1'b1;
         entry_in = 32'h8000_0000;
      end else begin
         hit_in = (b_near_ff <= b_far_ff) && (b_far_ff > 0);
         if (b_near_ff > SAT_MAX) entry_in = 32'h7fff_ffff;
         else if (b_near_ff < SAT_MIN) entry_in = 32'h8000_0000;
         else entry_in = b_near_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (enable) begin
         rsp_valid <= b_valid_ff;
      end
      if (enable) begin
         rsp_hit            <= hit_in;
         rsp_entry_distance <= entry_in;
      end
   end

   property p_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_distance);
   endproperty
   a_hold: assert property (p_hold) else $error("result changed while stalled");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready does not follow output stall");

   a_miss: assert property (@(posedge clock) disable iff (reset)
      enable && b_valid_ff && b_miss_ff |=> !rsp_hit && rsp_entry_distance == 0)
      else $error("miss result malformed");

endmodule : ray_box_slab_intersect_unit
`default_nettype wire
